>>> hdl/regex_dot_star_matcher_macros.svh
// Assertion macros for the dot-star matcher.
// RDSM_ASSERT checks a condition at every clock edge outside reset.
// RDSM_ASSERT_NEXT checks that a condition holds in the cycle after a trigger.
`ifndef REGEX_DOT_STAR_MATCHER_MACROS_SVH
`define REGEX_DOT_STAR_MATCHER_MACROS_SVH
`ifndef ASSERT_OFF
`define RDSM_ASSERT(label, ck, rs, cond) \
  label: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("assertion failed");
`define RDSM_ASSERT_NEXT(label, ck, rs, trig, cond) \
  label: assert property (@(posedge ck) disable iff (rs) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define RDSM_ASSERT(label, ck, rs, cond)
`define RDSM_ASSERT_NEXT(label, ck, rs, trig, cond)
`endif
`endif

>>> hdl/rdsm_pkg.sv
`default_nettype none
package rdsm_pkg;

  // Default capacity of the pattern in tokens.
  localparam int MAX_TOKENS_DEF = 32;

  // Command codes carried with each input item.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_TEXT   = 2'd2;
  localparam cmd_t CMD_END    = 2'd3;

  // Pattern error codes.
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_CAPACITY = 2'd1;
  localparam err_t ERR_STAR     = 2'd2;

  // Special pattern bytes.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h2E;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic       text_en;
    logic       restart;
    logic [7:0] data;
  } bus_t;

  // Controls addressed to one cell.
  typedef struct packed {
    logic used;
    logic wr_char;
    logic set_star;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hdl/rdsm_cell.sv
`default_nettype none
module rdsm_cell #(
  parameter bit START = 1'b0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rdsm_pkg::bus_t    bus,
  input  wire rdsm_pkg::cell_ctl_t ctl,
  input  wire logic              carry_in,
  input  wire logic              adv_in,
  output logic                   carry_out,
  output logic                   adv_out,
  output logic                   closed,
  output logic                   star_out
);

  logic [7:0] ch;
  logic       star;
  logic       act;
  logic       hit;

  // Position with star closure from the left neighbour.
  assign closed    = act | carry_in;
  assign carry_out = closed & star & ctl.used;
  assign star_out  = star;

  // Token compare against the text byte.
  assign hit     = ctl.used & closed & ((ch == rdsm_pkg::ANY_BYTE) || (ch == bus.data));
  assign adv_out = hit & ~star;

  // Token storage, written while the pattern is built.
  always_ff @(posedge clk) begin
    if (ctl.wr_char) begin
      ch   <= bus.data;
      star <= 1'b0;
    end else if (ctl.set_star) begin
      star <= 1'b1;
    end
  end

  // Active position bit.
  always_ff @(posedge clk) begin
    if (rst || bus.restart) begin
      act <= START;
    end else if (bus.text_en) begin
      act <= (hit & star) | adv_in;
    end
  end

endmodule
`default_nettype wire

>>> hdl/regex_dot_star_matcher.sv
// Whole-text matcher for patterns of literal bytes, '.' and 'x*'.
// Input channel (in_valid, in_stall, cmd, data_byte): clear the pattern,
// append a pattern byte, feed a text byte, or mark the end of the text.
// Output channel (out_valid, out_stall, matched, error): one item per
// end-of-text item, giving the match and the pattern error code.
// The block accepts one item per cycle while in_stall is low.
// The result of an end-of-text item appears in the output register on the
// cycle after it is accepted. The cycle time is set by the closure chain that
// ripples through the row of token cells, one cell per pattern token.
// Output is a single register: while it holds an item and the receiver
// stalls, in_stall is raised and no input is taken; once taken, a new
// result may be loaded in the same cycle.
// A synchronous reset empties the pattern, clears the error and out_valid,
// and sets the active vector to the start position. The pattern
// persists across texts until a clear item.
`default_nettype none
`include "regex_dot_star_matcher_macros.svh"
module regex_dot_star_matcher #(
  parameter int MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            matched,
  output logic [1:0]      error
);

  localparam int CNT_W = $clog2(MAX_TOKENS + 1);

  logic [CNT_W-1:0]        count;
  rdsm_pkg::err_t          pattern_error;
  logic                    act_last;
  logic                    acc;
  rdsm_pkg::bus_t          bus;
  rdsm_pkg::cell_ctl_t     ctl   [MAX_TOKENS];
  logic [MAX_TOKENS:0]     carry;
  logic [MAX_TOKENS:0]     adv;
  logic [MAX_TOKENS-1:0]   closed;
  logic [MAX_TOKENS-1:0]   star_vec;
  logic [MAX_TOKENS-1:0]   eq_cnt;
  logic [MAX_TOKENS-1:0]   eq_prev;
  logic                    is_star;
  logic                    last_star;
  logic                    full;
  logic                    do_append;
  logic                    do_set_star;
  logic                    accept_hit;

  assign in_stall = out_valid & out_stall;
  assign acc      = in_valid & ~in_stall;

  // Broadcast controls for the cell row.
  assign bus.data    = data_byte;
  assign bus.text_en = acc && (cmd == rdsm_pkg::CMD_TEXT);
  assign bus.restart = acc && (cmd != rdsm_pkg::CMD_TEXT);

  // Pattern building decisions.
  assign is_star     = (data_byte == rdsm_pkg::STAR_BYTE);
  assign last_star   = |(star_vec & eq_prev);
  assign full        = (count == CNT_W'(MAX_TOKENS));
  assign do_append   = acc && (cmd == rdsm_pkg::CMD_APPEND) &&
                       (pattern_error == rdsm_pkg::ERR_NONE);
  assign do_set_star = do_append && is_star && (count != '0) && !last_star;

  // Row of token cells with the closure and advance chains between them.
  assign carry[0] = 1'b0;
  assign adv[0]   = 1'b0;
  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    assign eq_cnt[i]       = (count == CNT_W'(i));
    assign eq_prev[i]      = (count == CNT_W'(i + 1));
    assign ctl[i].used     = (CNT_W'(i) < count);
    assign ctl[i].wr_char  = do_append && !is_star && !full && eq_cnt[i];
    assign ctl[i].set_star = do_set_star && eq_prev[i];
    rdsm_cell #(
      .START(i == 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .bus      (bus),
      .ctl      (ctl[i]),
      .carry_in (carry[i]),
      .adv_in   (adv[i]),
      .carry_out(carry[i+1]),
      .adv_out  (adv[i+1]),
      .closed   (closed[i]),
      .star_out (star_vec[i])
    );
  end

  // Accepting position with closure, picked at the token count.
  assign accept_hit = |(closed & eq_cnt) | (full & (act_last | carry[MAX_TOKENS]));

  // Final position beyond the last cell.
  always_ff @(posedge clk) begin
    if (rst || bus.restart) begin
      act_last <= 1'b0;
    end else if (bus.text_en) begin
      act_last <= adv[MAX_TOKENS];
    end
  end

  // Token count and sticky pattern error.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      pattern_error <= rdsm_pkg::ERR_NONE;
    end else if (acc && (cmd == rdsm_pkg::CMD_CLEAR)) begin
      count         <= '0;
      pattern_error <= rdsm_pkg::ERR_NONE;
    end else if (do_append) begin
      if (is_star) begin
        if (!do_set_star) begin
          pattern_error <= rdsm_pkg::ERR_STAR;
        end
      end else if (full) begin
        pattern_error <= rdsm_pkg::ERR_CAPACITY;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Output register for end-of-text results.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && (cmd == rdsm_pkg::CMD_END)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (cmd == rdsm_pkg::CMD_END)) begin
      matched <= (pattern_error == rdsm_pkg::ERR_NONE) && accept_hit;
      error   <= pattern_error;
    end
  end

  // A match is never reported together with a pattern error.
  `RDSM_ASSERT(a_match_no_err, clk, rst, !(out_valid && matched && (error != rdsm_pkg::ERR_NONE)))
  // The token count never passes the capacity.
  `RDSM_ASSERT(a_count_cap, clk, rst, count <= CNT_W'(MAX_TOKENS))
  // A clear empties the pattern and the error by the next cycle.
  `RDSM_ASSERT_NEXT(a_clear, clk, rst, acc && (cmd == rdsm_pkg::CMD_CLEAR), (count == '0) && (pattern_error == rdsm_pkg::ERR_NONE))
  // An accepted non-star append with no error set and room left grows the pattern by one token.
  `RDSM_ASSERT_NEXT(a_append_grow, clk, rst, do_append && !is_star && !full, count == $past(count) + CNT_W'(1))
  // At most one cell is written per cycle.
  `RDSM_ASSERT(a_one_write, clk, rst, $onehot0(eq_cnt))

endmodule
`default_nettype wire
